FILE: rtl/sfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_pkg: shared types and constants for the substring first-match unit
// Payload structs, config register indexes, the front-to-back event and
// the byte folding helper.
// ----------------------------------------------------------------------------
package sfm_pkg;

  // Sizing
  localparam int MAX_NEEDLE    = 32;
  localparam int POSITION_BITS = 16;
  localparam int NEEDLE_WORDS  = 4;
  localparam int WORD_BITS     = 64;
  localparam int NEEDLE_BYTES  = NEEDLE_WORDS * WORD_BITS / 8;
  localparam int LEN_REG_BITS  = 6;
  localparam int LEN_BITS      = $clog2(MAX_NEEDLE + 1);
  localparam int POS_OUT_BITS  = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = $clog2(QDEPTH);

  // Config register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEEDLE_0_7   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEEDLE_8_15  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEEDLE_16_23 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEEDLE_24_31 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEEDLE_LEN   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IGNORE_CASE  = 3'd5;

  // Input request
  typedef struct packed {
    logic [7:0] hay_byte;
    logic       hay_last;
  } in_item_t;

  // Result request
  typedef struct packed {
    logic                    found;
    logic [POS_OUT_BITS-1:0] match_position;
  } out_item_t;

  // Needle as seen by the window compare: lane j faces window byte j
  typedef struct packed {
    logic [MAX_NEEDLE-1:0][7:0] lane_byte;
    logic [MAX_NEEDLE-1:0]      lane_en;
    logic [LEN_BITS-1:0]        len;
    logic                       fold_en;
  } match_cfg_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic                    hit;
    logic                    last;
    logic [POS_OUT_BITS-1:0] pos;
  } event_t;

  // ASCII A-Z to a-z when enabled
  function automatic logic [7:0] fold_byte(logic [7:0] c, logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Reported position is the low bits of the start offset
  function automatic logic [POS_OUT_BITS-1:0] pos_out(logic [POSITION_BITS-1:0] p);
    return POS_OUT_BITS'(p);
  endfunction

endpackage

FILE: rtl/sfm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_cfg: configuration registers
// Holds needle words, length and case mode, and keeps a lane-aligned,
// pre-folded copy of the needle that is updated in the same write cycle.
// ----------------------------------------------------------------------------
module sfm_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sfm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sfm_pkg::WORD_BITS-1:0]     cfg_wdata,
  output sfm_pkg::match_cfg_t               mcfg
);

  logic [sfm_pkg::NEEDLE_WORDS-1:0][sfm_pkg::WORD_BITS-1:0] needle_r, needle_nxt;
  logic [sfm_pkg::LEN_REG_BITS-1:0] len_reg_r, len_reg_nxt;
  logic                             ign_r, ign_nxt;
  sfm_pkg::match_cfg_t              mcfg_r, mcfg_nxt;
  logic [sfm_pkg::NEEDLE_BYTES*8-1:0] needle_flat;
  logic [sfm_pkg::LEN_BITS-1:0]     len_eff;

  // Register writes
  always_comb begin
    needle_nxt  = needle_r;
    len_reg_nxt = len_reg_r;
    ign_nxt     = ign_r;
    if (cfg_we) begin
      case (cfg_index)
        sfm_pkg::CFG_NEEDLE_0_7:   needle_nxt[0] = cfg_wdata;
        sfm_pkg::CFG_NEEDLE_8_15:  needle_nxt[1] = cfg_wdata;
        sfm_pkg::CFG_NEEDLE_16_23: needle_nxt[2] = cfg_wdata;
        sfm_pkg::CFG_NEEDLE_24_31: needle_nxt[3] = cfg_wdata;
        sfm_pkg::CFG_NEEDLE_LEN:   len_reg_nxt = cfg_wdata[sfm_pkg::LEN_REG_BITS-1:0];
        sfm_pkg::CFG_IGNORE_CASE:  ign_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Length clamp
  always_comb begin
    if (int'(len_reg_nxt) > sfm_pkg::MAX_NEEDLE) begin
      len_eff = sfm_pkg::LEN_BITS'(sfm_pkg::MAX_NEEDLE);
    end else begin
      len_eff = sfm_pkg::LEN_BITS'(len_reg_nxt);
    end
  end

  assign needle_flat = needle_nxt;

  // Align needle to the window tail: lane j takes needle byte j+len-MAX
  always_comb begin
    int         nidx;
    logic [7:0] b;
    mcfg_nxt         = '0;
    mcfg_nxt.len     = len_eff;
    mcfg_nxt.fold_en = ign_nxt;
    for (int j = 0; j < sfm_pkg::MAX_NEEDLE; j++) begin
      nidx = j + int'(len_eff) - sfm_pkg::MAX_NEEDLE;
      b    = 8'h00;
      if ((nidx >= 0) && (nidx < sfm_pkg::NEEDLE_BYTES)) begin
        b = needle_flat[nidx*8 +: 8];
      end
      mcfg_nxt.lane_en[j]   = (nidx >= 0);
      mcfg_nxt.lane_byte[j] = sfm_pkg::fold_byte(b, ign_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r  <= '0;
      len_reg_r <= '0;
      ign_r     <= 1'b0;
      mcfg_r    <= '0;
    end else begin
      needle_r  <= needle_nxt;
      len_reg_r <= len_reg_nxt;
      ign_r     <= ign_nxt;
      mcfg_r    <= mcfg_nxt;
    end
  end

  assign mcfg = mcfg_r;

endmodule

FILE: rtl/sfm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_front: byte intake and window compare
// Shifts each byte into the window, counts bytes, compares the whole
// window tail against the needle in parallel and queues hits and ends.
// ----------------------------------------------------------------------------
module sfm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sfm_pkg::in_item_t    in_data,
  input  sfm_pkg::match_cfg_t  mcfg,
  input  logic                 q_full,
  output logic                 q_push,
  output sfm_pkg::event_t      q_data
);

  logic [sfm_pkg::MAX_NEEDLE-1:0][7:0]  window_r, window_nxt, window_sh;
  logic [sfm_pkg::POSITION_BITS-1:0]    count_r, count_nxt, count_inc, len_ext, pos;
  logic [sfm_pkg::MAX_NEEDLE-1:0]       lane_ok;
  logic accept, len_nz, exact, cmp_en, hit_len0, hit;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  assign len_nz    = (mcfg.len != '0);
  assign exact     = (count_r != '1);
  assign count_inc = count_r + 1'b1;
  assign len_ext   = sfm_pkg::POSITION_BITS'(mcfg.len);

  // Newest byte enters at the top
  assign window_sh = {in_data.hay_byte, window_r[sfm_pkg::MAX_NEEDLE-1:1]};

  // Per-lane compare, idle lanes pass
  always_comb begin
    for (int j = 0; j < sfm_pkg::MAX_NEEDLE; j++) begin
      lane_ok[j] = ~mcfg.lane_en[j] |
                   (sfm_pkg::fold_byte(window_sh[j], mcfg.fold_en) == mcfg.lane_byte[j]);
    end
  end

  assign cmp_en   = len_nz & exact & (count_inc >= len_ext);
  assign hit_len0 = ~len_nz & (count_r == '0);
  assign hit      = hit_len0 | (cmp_en & (&lane_ok));
  assign pos      = hit_len0 ? '0 : (count_inc - len_ext);

  // Only hits and haystack ends matter downstream
  assign q_push      = accept & (hit | in_data.hay_last);
  assign q_data.hit  = hit;
  assign q_data.last = in_data.hay_last;
  assign q_data.pos  = sfm_pkg::pos_out(pos);

  // Window and counter update
  always_comb begin
    window_nxt = window_r;
    count_nxt  = count_r;
    if (accept) begin
      if (in_data.hay_last) begin
        window_nxt = '0;
        count_nxt  = '0;
      end else if (len_nz) begin
        window_nxt = window_sh;
        if (exact) begin
          count_nxt = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      count_r  <= '0;
    end else begin
      window_r <= window_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/sfm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_fifo: event queue
// Short queue of classified events between the front and the back.
// ----------------------------------------------------------------------------
module sfm_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfm_pkg::event_t  push_data,
  input  logic             pop,
  output sfm_pkg::event_t  head,
  output logic             empty,
  output logic             full
);

  sfm_pkg::event_t                mem_r [sfm_pkg::QDEPTH];
  logic [sfm_pkg::QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [sfm_pkg::QPTR_BITS:0]    cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (sfm_pkg::QPTR_BITS+1)'(sfm_pkg::QDEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/sfm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_back: result issue
// Tracks whether the current haystack already reported, turns queued
// events into results and holds them in the output register.
// ----------------------------------------------------------------------------
module sfm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sfm_pkg::event_t     q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sfm_pkg::out_item_t  out_data
);

  logic               given_r, given_nxt;
  logic               out_valid_r, out_valid_nxt;
  sfm_pkg::out_item_t out_data_r, out_data_nxt;
  logic               can_take, emit;

  assign can_take = ~out_valid_r | ~out_stall;
  assign q_pop    = ~q_empty & can_take;
  // First hit of a haystack, or its end without a hit
  assign emit     = ~given_r & (q_head.hit | q_head.last);

  always_comb begin
    given_nxt     = given_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_data_nxt.found          = q_head.hit;
        out_data_nxt.match_position = q_head.hit ? q_head.pos : '0;
      end
      if (q_head.last) begin
        given_nxt = 1'b0;
      end else if (q_head.hit) begin
        given_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      given_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      given_r     <= given_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/substring_first_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_first_match_unit: streaming first-occurrence substring search
// Finds the first position of a configured needle in a byte stream.
//
//   channel  ports                        request
//   in       in_valid/in_stall/in_data    one haystack byte plus last flag
//   out      out_valid/out_stall/out_data found flag and start position
//   cfg      cfg_we/cfg_index/cfg_wdata   one register write, no wait
//
// One byte per cycle while in_stall is low; the whole window tail is compared
// against the needle in parallel in the intake cycle. A result goes from the
// causing byte through the event queue, then the output register. A stall on
// out fills the four-entry event queue before in_stall rises. Reset is
// synchronous and clears config, window, count and queue.
// ----------------------------------------------------------------------------
module substring_first_match_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sfm_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sfm_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [sfm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sfm_pkg::WORD_BITS-1:0]     cfg_wdata
);

  sfm_pkg::match_cfg_t mcfg;
  sfm_pkg::event_t     q_in, q_head;
  logic                q_push, q_pop, q_empty, q_full;

  sfm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mcfg      (mcfg)
  );

  sfm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .mcfg     (mcfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  sfm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  sfm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
